// File: design/rgbh_pkg.sv
// Shared constants, pipeline payload types and the division step for the RGB to HSV core.
package rgbh_pkg;

    localparam logic [5:0] C_HUE_STEP  = 6'd43;
    localparam logic [7:0] C_HUE_RED   = 8'd0;
    localparam logic [7:0] C_HUE_GREEN = 8'd85;
    localparam logic [7:0] C_HUE_BLUE  = 8'd171;

    // Number of restoring division steps, one quotient bit each.
    localparam int C_DIV_STEPS = 8;

    // Index of the last divider stage; stages 0 and 1 sit in the front end.
    localparam int C_LAST = C_DIV_STEPS + 1;

    // Result of the min/max stage.
    typedef struct packed {
        logic [7:0] hi;
        logic [7:0] span;
        logic [7:0] mag;
        logic       neg;
        logic [7:0] base;
    } t_front;

    // One division lane: partial remainder, numerator low bits that turn
    // into quotient bits as they shift out, and the divisor.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] nq;
        logic [7:0] d;
    } t_lane;

    // Values that ride along the divider without change.
    typedef struct packed {
        logic [7:0] brightness;
        logic [7:0] base;
        logic       neg;
        logic       hue_zero;
        logic       sat_zero;
    } t_side;

    typedef struct packed {
        t_lane sat;
        t_lane hue;
        t_side side;
    } t_div_stage;

    // One restoring step: shift in the next numerator bit, subtract the
    // divisor when it fits, and shift the quotient bit into the low end.
    function automatic t_lane f_div_step(input t_lane l);
        logic [8:0] t;
        logic       q;
        t_lane      o;
        t = {l.r, l.nq[7]};
        q = (t >= {1'b0, l.d});
        o.d = l.d;
        if (q) begin
            o.r = 8'(t - {1'b0, l.d});
        end else begin
            o.r = t[7:0];
        end
        o.nq = {l.nq[6:0], q};
        return o;
    endfunction

endpackage

// File: design/rgbh_pix_if.sv
// Input channel carrying one RGB pixel with a valid/ready handshake.
interface rgbh_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: design/rgbh_hsv_if.sv
// Output channel carrying one HSV result with a valid/ready handshake.
interface rgbh_hsv_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] hue;
    logic        [7:0] saturation;
    logic        [7:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

// File: design/rgb_to_hsv_8bit_core.sv
// Top level of the pipelined 8-bit RGB to HSV converter.
//
// A pixel request on i_pix (red, green, blue) is accepted when valid and
// ready are both high. Each request yields exactly one result on o_hsv:
// hue (signed, -43..214), saturation and brightness, all on a 0..255 scale.
// The core takes one pixel per clock while the receiver takes results. The
// path holds eleven registers: min/max, loaded at the accepting edge, the
// numerators, eight for the restoring divider (one quotient bit per stage,
// saturation and hue side by side) and the output register.
// Every stage carries its own valid bit and moves whenever the stage after
// it is empty or moving, so a stalled receiver holds the output register
// while empty stages further back keep filling. i_pix.ready drops only when
// every stage holds a pixel and the receiver is not taking the result.
// A synchronous reset on i_rst_n empties the pipeline; data registers are not reset.
module rgb_to_hsv_8bit_core
    import rgbh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rgbh_pix_if.sink   i_pix,
    rgbh_hsv_if.source o_hsv
);

    logic       w_valid [0:C_LAST];
    logic       w_en    [0:C_LAST];
    t_div_stage w_stage [1:C_LAST];
    logic       w_en_out;

    logic              r_out_valid;
    logic signed [8:0] r_hue;
    logic        [7:0] r_sat;
    logic        [7:0] r_bri;
    logic signed [8:0] n_hue;
    logic        [7:0] n_sat;
    logic signed [8:0] w_q_hue;

    always_comb begin
        w_en_out     = !r_out_valid || o_hsv.ready;
        w_en[C_LAST] = !w_valid[C_LAST] || w_en_out;
        for (int k = C_LAST - 1; k >= 0; k--) begin
            w_en[k] = !w_valid[k] || w_en[k + 1];
        end
    end

    assign i_pix.ready = w_en[0];

    rgbh_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en_a    (w_en[0]),
        .i_en_b    (w_en[1]),
        .i_valid   (i_pix.valid),
        .i_red     (i_pix.red),
        .i_green   (i_pix.green),
        .i_blue    (i_pix.blue),
        .o_valid_a (w_valid[0]),
        .o_valid_b (w_valid[1]),
        .o_stage   (w_stage[1])
    );

    for (genvar g = 0; g < C_DIV_STEPS; g++) begin : g_div
        rgbh_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[g + 2]),
            .i_valid (w_valid[g + 1]),
            .i_stage (w_stage[g + 1]),
            .o_valid (w_valid[g + 2]),
            .o_stage (w_stage[g + 2])
        );
    end

    // The hue quotient is the magnitude; the sign of the channel difference
    // is applied afterwards so the division truncates toward zero.
    always_comb begin
        w_q_hue = $signed({1'b0, w_stage[C_LAST].hue.nq});
        if (w_stage[C_LAST].side.hue_zero) begin
            n_hue = 9'sd0;
        end else if (w_stage[C_LAST].side.neg) begin
            n_hue = $signed({1'b0, w_stage[C_LAST].side.base}) - w_q_hue;
        end else begin
            n_hue = $signed({1'b0, w_stage[C_LAST].side.base}) + w_q_hue;
        end
        n_sat = w_stage[C_LAST].side.sat_zero ? 8'd0 : w_stage[C_LAST].sat.nq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= w_valid[C_LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_bri <= w_stage[C_LAST].side.brightness;
        end
    end

    assign o_hsv.valid      = r_out_valid;
    assign o_hsv.hue        = r_hue;
    assign o_hsv.saturation = r_sat;
    assign o_hsv.brightness = r_bri;

    // A grey or black pixel never carries a hue.
    a_grey_no_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hsv.valid && o_hsv.saturation == 8'd0) |-> (o_hsv.hue == 9'sd0))
        else $error("hue set on a pixel without saturation");

    // A black pixel has no saturation.
    a_black_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hsv.valid && o_hsv.brightness == 8'd0) |-> (o_hsv.saturation == 8'd0))
        else $error("saturation set on a black pixel");

    // Hue stays within the unwrapped range.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hsv.valid |-> (o_hsv.hue >= -9'sd43 && o_hsv.hue <= 9'sd214))
        else $error("hue out of range");

    // The input is held off only while a result waits on a stalled receiver.
    a_backpressure_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (o_hsv.valid && !o_hsv.ready))
        else $error("input stalled without a stalled output");

endmodule

// File: design/rgbh_front.sv
// Min/max and sector selection stage followed by the numerator setup stage.
module rgbh_front
    import rgbh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en_a,
    input  logic       i_en_b,
    input  logic       i_valid,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid_a,
    output logic       o_valid_b,
    output t_div_stage o_stage
);

    logic       r_valid_a;
    logic       r_valid_b;
    t_front     r_front;
    t_front     n_front;
    t_div_stage r_stage;
    t_div_stage n_stage;

    logic [7:0]        w_hi;
    logic [7:0]        w_lo;
    logic signed [8:0] w_diff;
    logic [15:0]       w_num_sat;
    logic [15:0]       w_num_hue;

    always_comb begin
        w_hi = (i_red > i_green) ? i_red : i_green;
        if (i_blue > w_hi) begin
            w_hi = i_blue;
        end
        w_lo = (i_red < i_green) ? i_red : i_green;
        if (i_blue < w_lo) begin
            w_lo = i_blue;
        end

        // Red wins ties with green and blue, then green wins over blue.
        if (w_hi == i_red) begin
            w_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
            n_front.base = C_HUE_RED;
        end else if (w_hi == i_green) begin
            w_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
            n_front.base = C_HUE_GREEN;
        end else begin
            w_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
            n_front.base = C_HUE_BLUE;
        end

        n_front.hi   = w_hi;
        n_front.span = w_hi - w_lo;
        n_front.neg  = w_diff[8];
        n_front.mag  = w_diff[8] ? 8'(-w_diff) : w_diff[7:0];
    end

    always_comb begin
        w_num_sat = {r_front.span, 8'd0} - {8'd0, r_front.span};
        w_num_hue = {8'd0, r_front.mag} * {10'd0, C_HUE_STEP};

        // The high byte of each numerator is already below its divisor, so
        // eight steps leave the full quotient.
        n_stage.sat.r  = w_num_sat[15:8];
        n_stage.sat.nq = w_num_sat[7:0];
        n_stage.sat.d  = r_front.hi;
        n_stage.hue.r  = w_num_hue[15:8];
        n_stage.hue.nq = w_num_hue[7:0];
        n_stage.hue.d  = r_front.span;

        n_stage.side.brightness = r_front.hi;
        n_stage.side.base       = r_front.base;
        n_stage.side.neg        = r_front.neg;
        n_stage.side.hue_zero   = (r_front.span == 8'd0);
        n_stage.side.sat_zero   = (r_front.hi == 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (i_en_a) begin
                r_valid_a <= i_valid;
            end
            if (i_en_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_front <= n_front;
        end
        if (i_en_b) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid_a = r_valid_a;
    assign o_valid_b = r_valid_b;
    assign o_stage   = r_stage;

endmodule

// File: design/rgbh_div_step.sv
// One register stage of the two-lane restoring divider.
module rgbh_div_step
    import rgbh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_div_stage i_stage,
    output logic       o_valid,
    output t_div_stage o_stage
);

    logic       r_valid;
    t_div_stage r_stage;
    t_div_stage n_stage;

    always_comb begin
        n_stage.sat  = f_div_step(i_stage.sat);
        n_stage.hue  = f_div_step(i_stage.hue);
        n_stage.side = i_stage.side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
